### hw/rtl/sacn_pkg.sv
package sacn_pkg;

	localparam int MAX_SLOTS        = 512;
	localparam int MIN_PACKET_BYTES = 126;
	localparam int SLOT_LIMIT       = (MAX_SLOTS < 512) ? MAX_SLOTS : 512;
	localparam int OFFSET_W         = 11;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = 11'd2047;
	localparam int PADDR_W          = 5;

	// register indexes
	localparam logic [2:0] REG_UNIV_BASE  = 3'd0;
	localparam logic [2:0] REG_UNIV_COUNT = 3'd1;
	localparam logic [2:0] REG_DMX_CHAN   = 3'd2;
	localparam logic [2:0] REG_TIMEOUT    = 3'd3;
	localparam logic [2:0] REG_OVERRIDE   = 3'd4;

	// packet status codes
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SHORT    = 4'd1;
	localparam logic [3:0] ST_PREAMBLE = 4'd2;
	localparam logic [3:0] ST_IDENT    = 4'd3;
	localparam logic [3:0] ST_FLAGS    = 4'd4;
	localparam logic [3:0] ST_VECTOR   = 4'd5;
	localparam logic [3:0] ST_DMP      = 4'd6;
	localparam logic [3:0] ST_ADDR     = 4'd7;
	localparam logic [3:0] ST_COUNT    = 4'd8;
	localparam logic [3:0] ST_UNIVERSE = 4'd9;

	// header offsets
	localparam logic [OFFSET_W-1:0] OFF_PREAMBLE  = 11'd1;
	localparam logic [OFFSET_W-1:0] OFF_IDENT_LO  = 11'd4;
	localparam logic [OFFSET_W-1:0] OFF_IDENT_HI  = 11'd12;
	localparam logic [OFFSET_W-1:0] OFF_FLAGS     = 11'd39;
	localparam logic [OFFSET_W-1:0] OFF_VECTOR    = 11'd43;
	localparam logic [OFFSET_W-1:0] OFF_SEQUENCE  = 11'd111;
	localparam logic [OFFSET_W-1:0] OFF_UNIVERSE  = 11'd114;
	localparam logic [OFFSET_W-1:0] OFF_DMP       = 11'd117;
	localparam logic [OFFSET_W-1:0] OFF_ADDR      = 11'd118;
	localparam logic [OFFSET_W-1:0] OFF_COUNT     = 11'd124;
	localparam logic [OFFSET_W-1:0] OFF_DATA      = 11'd126;

	localparam logic [15:0] PREAMBLE_SIZE = 16'h0010;
	localparam logic [31:0] FLAGS_MASK    = 32'h0000_7000;
	localparam logic [31:0] FRAME_VECTOR  = 32'h0000_0002;
	localparam logic [7:0]  DMP_VECTOR    = 8'h02;
	localparam logic [7:0]  ADDR_TYPE     = 8'hA1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        slot_valid;
		logic [8:0]  slot_index;
		logic [7:0]  slot_value;
		logic        slot_in_dmx;
		logic        packet_done;
		logic [3:0]  packet_status;
		logic [15:0] universe;
		logic [7:0]  sequence_res;
		logic [9:0]  slot_count;
		logic        network_active;
		logic        has_data;
	} out_item_t;

	typedef struct packed {
		logic [15:0] universe_base;
		logic [15:0] universe_count;
		logic [9:0]  dmx_channels;
		logic [15:0] timeout_ms;
		logic        manual_override;
	} cfg_t;

	// "ASC-E1.17"
	function automatic logic [7:0] acn_ident(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h41;
			4'd1: c = 8'h53;
			4'd2: c = 8'h43;
			4'd3: c = 8'h2D;
			4'd4: c = 8'h45;
			4'd5: c = 8'h31;
			4'd6: c = 8'h2E;
			4'd7: c = 8'h31;
			4'd8: c = 8'h37;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/sacn_cfg_regs.sv
module sacn_cfg_regs
	import sacn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[PADDR_W-1:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.universe_base   <= 16'd0;
			cfg_q.universe_count  <= 16'd1;
			cfg_q.dmx_channels    <= 10'd512;
			cfg_q.timeout_ms      <= 16'd1000;
			cfg_q.manual_override <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_UNIV_BASE:  cfg_q.universe_base   <= pwdata[15:0];
				REG_UNIV_COUNT: cfg_q.universe_count  <= pwdata[15:0];
				REG_DMX_CHAN:   cfg_q.dmx_channels    <= pwdata[9:0];
				REG_TIMEOUT:    cfg_q.timeout_ms      <= pwdata[15:0];
				REG_OVERRIDE:   cfg_q.manual_override <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_UNIV_BASE:  prdata = {16'd0, cfg_q.universe_base};
			REG_UNIV_COUNT: prdata = {16'd0, cfg_q.universe_count};
			REG_DMX_CHAN:   prdata = {22'd0, cfg_q.dmx_channels};
			REG_TIMEOUT:    prdata = {16'd0, cfg_q.timeout_ms};
			REG_OVERRIDE:   prdata = {31'd0, cfg_q.manual_override};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/sacn_parser.sv
module sacn_parser
	import sacn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_present,
	output out_item_t res
);

	logic [OFFSET_W-1:0] byte_offset_q;
	logic [3:0]          error_code_q;
	logic [31:0]         header_word_q;
	logic [15:0]         cur_universe_q;
	logic [7:0]          cur_sequence_q;
	logic [15:0]         property_count_q;
	logic [9:0]          slots_seen_q;
	logic [15:0]         ms_since_packet_q;
	logic                active_q;

	logic [OFFSET_W-1:0] off_n;
	logic [3:0]          err_n;
	logic [31:0]         hw_n;
	logic [15:0]         uni_n;
	logic [7:0]          seq_n;
	logic [15:0]         pc_n;
	logic [9:0]          slots_n;
	logic [15:0]         ms_n;
	logic                active_n;
	logic [OFFSET_W-1:0] off_m4;
	logic [OFFSET_W-1:0] idx;
	logic                emit;
	logic                in_win;
	logic [3:0]          status;
	logic [7:0]          b;
	logic                is_tick;

	assign b       = item.data_byte;
	assign is_tick = item.req_type;
	assign off_m4  = byte_offset_q - OFF_IDENT_LO;
	assign idx     = byte_offset_q - OFF_DATA;
	assign hw_n    = {header_word_q[23:0], b};
	assign in_win  = (cur_universe_q >= cfg.universe_base) &&
		((cur_universe_q - cfg.universe_base) < cfg.universe_count);

	always_comb begin
		off_n    = byte_offset_q;
		err_n    = error_code_q;
		uni_n    = cur_universe_q;
		seq_n    = cur_sequence_q;
		pc_n     = property_count_q;
		slots_n  = slots_seen_q;
		ms_n     = ms_since_packet_q;
		active_n = active_q;
		emit     = 1'b0;
		status   = ST_OK;
		res      = '0;

		if (is_tick) begin
			if (ms_since_packet_q != 16'hFFFF)
				ms_n = ms_since_packet_q + 16'd1;
			active_n = ms_n < cfg.timeout_ms;
		end else begin
			if (byte_offset_q == OFF_PREAMBLE) begin
				if (hw_n[15:0] != PREAMBLE_SIZE && err_n == ST_OK) err_n = ST_PREAMBLE;
			end else if (byte_offset_q >= OFF_IDENT_LO && byte_offset_q <= OFF_IDENT_HI) begin
				if (b != acn_ident(off_m4[3:0]) && err_n == ST_OK) err_n = ST_IDENT;
			end else if (byte_offset_q == OFF_FLAGS) begin
				if ((hw_n & FLAGS_MASK) != FLAGS_MASK && err_n == ST_OK) err_n = ST_FLAGS;
			end else if (byte_offset_q == OFF_VECTOR) begin
				if (hw_n != FRAME_VECTOR && err_n == ST_OK) err_n = ST_VECTOR;
			end else if (byte_offset_q == OFF_SEQUENCE) begin
				seq_n = b;
			end else if (byte_offset_q == OFF_UNIVERSE) begin
				uni_n = hw_n[15:0];
			end else if (byte_offset_q == OFF_DMP) begin
				if (b != DMP_VECTOR && err_n == ST_OK) err_n = ST_DMP;
			end else if (byte_offset_q == OFF_ADDR) begin
				if (b != ADDR_TYPE && err_n == ST_OK) err_n = ST_ADDR;
			end else if (byte_offset_q == OFF_COUNT) begin
				pc_n = hw_n[15:0];
				if (pc_n < 16'd2 && err_n == ST_OK) err_n = ST_COUNT;
				if (!in_win && err_n == ST_OK) err_n = ST_UNIVERSE;
			end else if (byte_offset_q >= OFF_DATA && byte_offset_q != OFFSET_MAX &&
				error_code_q == ST_OK) begin
				if (property_count_q >= 16'd2 &&
					{5'd0, idx} < (property_count_q - 16'd1) &&
					idx < OFFSET_W'(SLOT_LIMIT)) begin
					emit            = 1'b1;
					res.slot_valid  = 1'b1;
					res.slot_index  = idx[8:0];
					res.slot_value  = b;
					res.slot_in_dmx = idx < {1'b0, cfg.dmx_channels};
					if (slots_seen_q != 10'h3FF)
						slots_n = slots_seen_q + 10'd1;
				end
			end

			if (byte_offset_q != OFFSET_MAX)
				off_n = byte_offset_q + 11'd1;

			if (item.last_byte) begin
				// short packets override any header error
				status = (byte_offset_q < OFFSET_W'(MIN_PACKET_BYTES - 1)) ? ST_SHORT : err_n;
				res.packet_done   = 1'b1;
				res.packet_status = status;
				res.universe      = uni_n;
				res.sequence_res  = seq_n;
				res.slot_count    = (status == ST_OK) ? slots_n : 10'd0;
				if (status == ST_OK) begin
					ms_n     = 16'd0;
					active_n = 1'b1;
				end
			end
		end

		res.network_active = active_n;
		res.has_data       = active_n && !cfg.manual_override;
	end

	assign res_present = is_tick || emit || item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q     <= '0;
			error_code_q      <= ST_OK;
			header_word_q     <= '0;
			cur_universe_q    <= '0;
			cur_sequence_q    <= '0;
			property_count_q  <= '0;
			slots_seen_q      <= '0;
			ms_since_packet_q <= '0;
			active_q          <= 1'b0;
		end else if (fire) begin
			ms_since_packet_q <= ms_n;
			active_q          <= active_n;
			if (!is_tick) begin
				if (item.last_byte) begin
					byte_offset_q    <= '0;
					error_code_q     <= ST_OK;
					header_word_q    <= '0;
					cur_universe_q   <= '0;
					cur_sequence_q   <= '0;
					property_count_q <= '0;
					slots_seen_q     <= '0;
				end else begin
					byte_offset_q    <= off_n;
					error_code_q     <= err_n;
					header_word_q    <= hw_n;
					cur_universe_q   <= uni_n;
					cur_sequence_q   <= seq_n;
					property_count_q <= pc_n;
					slots_seen_q     <= slots_n;
				end
			end
		end
	end

endmodule

### hw/rtl/sacn_data_packet_receiver_core.sv
// sACN (E1.31) data packet receiver.
// Input channel (in_valid/in_ready/in_data): one transfer per UDP payload byte,
// last_byte set on the final byte, or a 1 ms tick with req_type set.
// Output channel (out_valid/out_ready/out_data): zero or one result per input
// transfer: a slot byte, a packet status (on the last byte), both, or the
// link flags after a tick. Bytes that yield nothing produce no transfer.
// APB port: universe window, DMX channel count, timeout and override
// registers at 4-byte strides; write only while the block is idle.
// Each item passes through the input register, then the result register,
// from which its result is offered. Throughput: one item per cycle while
// out_ready does not stall the output, set by the single combinational
// header/slot decode between the two registers.
// When out_ready is low the result register holds, the input register fills
// and in_ready then drops; no item is lost. in_ready depends combinationally
// on out_ready.
// Reset clears parser state, link timer and flags and loads register
// defaults; both pipeline registers come up empty.
module sacn_data_packet_receiver_core
	import sacn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      advance;
	logic      fire;
	logic      res_present;
	out_item_t res;
	cfg_t      cfg;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign pready   = 1'b1;

	sacn_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	sacn_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.cfg        (cfg),
		.res_present(res_present),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_present;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_present)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hw/rtl/sacn_checker.sv
module sacn_checker
	import sacn_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	input logic      pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.has_data |-> out_data.network_active)
		else $error("has_data without network_active");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.packet_done && out_data.packet_status != ST_OK |->
		out_data.slot_count == 10'd0)
		else $error("slot count on failed packet");

	a_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.packet_done |->
		out_data.packet_status == ST_OK && out_data.universe == 16'd0 &&
		out_data.slot_count == 10'd0)
		else $error("status fields set without packet close");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind sacn_data_packet_receiver_core sacn_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data),
	.pready   (pready)
);
